### design/swmq_pkg.sv
package swmq_pkg;

	localparam int DEPTH       = 64;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_POP  = 3'd1,
		CMD_PEEK = 3'd2,
		CMD_DUMP = 3'd3,
		CMD_MIN  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DUMP,
		S_MIN,
		S_MINOUT
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] value;
	} op_t;

endpackage

### design/swmq_if.sv
interface swmq_req_if;
	import swmq_pkg::*;

	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [31:0] push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface swmq_rsp_if;
	import swmq_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic               last_item;

	modport source (output valid, output status, output out_value, output last_item,
		input ready);
	modport sink (input valid, input status, input out_value, input last_item,
		output ready);
endinterface

### design/swmq_ram.sv
module swmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/swmq_front.sv
module swmq_front import swmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	swmq_req_if.sink   req,
	output logic       op_valid,
	output op_t        op,
	input  logic       op_ready
);

	logic valid_s1;
	op_t  op_s1;
	logic cmd_ok;
	logic take;

	always_comb begin
		unique case (req.cmd)
			CMD_PUSH, CMD_POP, CMD_PEEK, CMD_DUMP, CMD_MIN: cmd_ok = 1'b1;
			default:                                         cmd_ok = 1'b0;
		endcase
	end

	assign req.ready = !valid_s1 || op_ready;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= cmd_ok;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1.cmd   <= cmd_t'(req.cmd);
			op_s1.value <= req.push_value;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

### design/swmq_fifo.sv
module swmq_fifo import swmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  op_t  push_op,
	output logic push_ready,
	output logic pop_valid,
	output op_t  pop_op,
	input  logic pop_ready
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

### design/swmq_back.sv
module swmq_back import swmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	input  op_t       op,
	output logic      op_ready,
	swmq_rsp_if.source rsp
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [ADDR_W-1:0]  idx_q, idx_d;
	logic signed [31:0] best_q, best_d;
	logic               ovalid_q;
	status_t            ostatus_q;
	logic signed [31:0] ovalue_q;
	logic               olast_q;

	logic               out_free;
	logic               emit;
	status_t            e_status;
	logic signed [31:0] e_value;
	logic               e_last;
	logic               ram_we;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;
	logic signed [31:0] rd_val;
	logic [ADDR_W-1:0]  last_idx;
	logic               full;
	logic               empty;

	swmq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (op.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_val   = $signed(ram_rdata);
	assign last_idx = ADDR_W'(count_q - CNT_W'(1));
	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign out_free = !ovalid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		best_d    = best_q;
		op_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		emit      = 1'b0;
		e_status  = ST_OK;
		e_value   = '0;
		e_last    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (op_valid && out_free) begin
					op_ready = 1'b1;
					unique case (op.cmd)
						CMD_PUSH: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = last_idx;
								state_d   = S_READ;
								if (op.cmd == CMD_POP) begin
									count_d = count_q - 1'b1;
								end
							end
						end
						CMD_DUMP, CMD_MIN: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								idx_d     = '0;
								state_d   = (op.cmd == CMD_DUMP) ? S_DUMP : S_MIN;
							end
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					emit    = 1'b1;
					e_value = rd_val;
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					emit    = 1'b1;
					e_value = rd_val;
					e_last  = idx_q == last_idx;
					if (idx_q == last_idx) begin
						state_d = S_IDLE;
					end else begin
						idx_d     = idx_q + 1'b1;
						ram_re    = 1'b1;
						ram_raddr = idx_q + 1'b1;
					end
				end
			end
			S_MIN: begin
				best_d = (idx_q == '0 || rd_val < best_q) ? rd_val : best_q;
				if (idx_q == last_idx) begin
					state_d = S_MINOUT;
				end else begin
					idx_d     = idx_q + 1'b1;
					ram_re    = 1'b1;
					ram_raddr = idx_q + 1'b1;
				end
			end
			S_MINOUT: begin
				if (out_free) begin
					emit    = 1'b1;
					e_value = best_q;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_d;
		if (emit) begin
			ostatus_q <= e_status;
			ovalue_q  <= e_value;
			olast_q   <= e_last;
		end
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.status    = ostatus_q;
	assign rsp.out_value = ovalue_q;
	assign rsp.last_item = olast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP || state_q == S_MIN) |-> (CNT_W'(idx_q) < count_q))
		else $error("scan index past top of stack");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(state_q == S_IDLE && op_ready))
		else $error("entry count changed outside a command start");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result written over an untaken result");

endmodule

### design/stack_with_min_query.sv
// Path: an accepted item passes the front register and queue to the back end. Push and
// errors reach the result register from idle; pop and peek first do one RAM read in
// S_READ; minimum scans every stored entry in S_MIN and sends the result from S_MINOUT.
// While results are taken: one push per cycle; dump sends n transfers, one per cycle.
// Reset: arst_n clears the entry count, queue and output valid; stack RAM is not cleared.
module stack_with_min_query import swmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	swmq_req_if.sink   req,
	swmq_rsp_if.source rsp
);

	logic op_valid_f;
	op_t  op_f;
	logic op_ready_f;
	logic op_valid_b;
	op_t  op_b;
	logic op_ready_b;

	swmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op_valid (op_valid_f),
		.op       (op_f),
		.op_ready (op_ready_f)
	);

	swmq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (op_valid_f),
		.push_op    (op_f),
		.push_ready (op_ready_f),
		.pop_valid  (op_valid_b),
		.pop_op     (op_b),
		.pop_ready  (op_ready_b)
	);

	swmq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid_b),
		.op       (op_b),
		.op_ready (op_ready_b),
		.rsp      (rsp)
	);

endmodule
